>>> src/ffha_pkg.sv
package ffha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int AW = $clog2(HEAP_BYTES);   // byte offset inside the heap
  localparam int OW = AW + 1;               // offset that can also hold HEAP_BYTES

  // Fixed field widths of the channels
  localparam int SIZE_W  = 13;
  localparam int FADDR_W = 13;
  localparam int BADDR_W = 12;
  localparam int REM_W   = 13;
  localparam int CW      = OW + SIZE_W;     // wide enough for size compares

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  // One block header in the header store
  typedef struct packed {
    logic          valid;
    logic          free;
    logic [AW-1:0] size;
    logic [AW-1:0] prev;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_LATCH,
    OP_A_RD,
    OP_A_CHK,
    OP_A_SPL,
    OP_A_TAKE,
    OP_FAIL_NS,
    OP_FAIL_BAD,
    OP_LK_RD,
    OP_LK_WR,
    OP_F_RD,
    OP_F_MARK,
    OP_F_PRD,
    OP_F_PMRG,
    OP_F_INV,
    OP_F_NRD,
    OP_F_NMRG,
    OP_F_LNK,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic off_end;
    logic fit;
    logic split;
    logic faddr_bad;
    logic hdr_bad;
    logic cur_zero;
    logic nb_free;
    logic nxt_in;
    logic lnk_in;
    logic split_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/ffha_if.sv
interface ffha_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ffha_pkg::SIZE_W-1:0]   alloc_size;
  logic [ffha_pkg::FADDR_W-1:0]  free_addr;

  modport source(output valid, req_type, alloc_size, free_addr, input ready);
  modport sink(input valid, req_type, alloc_size, free_addr, output ready);
endinterface

interface ffha_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ffha_pkg::BADDR_W-1:0]  block_addr;
  logic [ffha_pkg::REM_W-1:0]    remaining;

  modport source(output valid, status, block_addr, remaining, input ready);
  modport sink(input valid, status, block_addr, remaining, output ready);
endinterface

>>> src/first_fit_heap_allocator_core.sv
// Channel    Direction  Fields
// in_chan    input      req_type, alloc_size, free_addr
// out_chan   output     status, block_addr, remaining
//
// An allocate walks the block headers from offset zero until a free block fits
// or the walk passes the end of the heap, then takes that block; a free checks
// the address and merges the freed block with free neighbours.
// Ready returns at the same edge that loads the result register.
// After reset the header store is swept once before the first transaction is
// accepted. A stalled result waits in the output register.
module first_fit_heap_allocator_core (
  input logic        clk,
  input logic        rst_n,
  ffha_in_if.sink    in_chan,
  ffha_out_if.source out_chan
);

  ffha_pkg::ctl_cmd_t   cmd;
  ffha_pkg::dp_status_t st;

  // Sequencer
  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .st          (st),
    .cmd         (cmd)
  );

  // Header store, counters and result register
  ffha_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_alloc_size  (in_chan.alloc_size),
    .in_free_addr   (in_chan.free_addr),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_status     (out_chan.status),
    .out_block_addr (out_chan.block_addr),
    .out_remaining  (out_chan.remaining)
  );

endmodule

>>> src/ffha_ram.sv
module ffha_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/ffha_ctrl.sv
module ffha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_ready,
  input  ffha_pkg::dp_status_t st,
  output ffha_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_A_RD  = 19'h00004,
    S_A_CHK = 19'h00008,
    S_A_SPL = 19'h00010,
    S_A_TK  = 19'h00020,
    S_LK_RD = 19'h00040,
    S_LK_WR = 19'h00080,
    S_F_CHK = 19'h00100,
    S_F_HDR = 19'h00200,
    S_F_PRD = 19'h00400,
    S_F_PCK = 19'h00800,
    S_F_INV = 19'h01000,
    S_F_NRD = 19'h02000,
    S_F_NCK = 19'h04000,
    S_F_INN = 19'h08000,
    S_F_LNK = 19'h10000,
    S_DONE  = 19'h20000,
    S_SPARE = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd.op    = ffha_pkg::OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = ffha_pkg::OP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = ffha_pkg::OP_LATCH;
          state_nxt = (in_req_type == ffha_pkg::REQ_FREE) ? S_F_CHK : S_A_RD;
        end
      end
      S_A_RD: begin
        if (st.off_end) begin
          cmd.op    = ffha_pkg::OP_FAIL_NS;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffha_pkg::OP_A_RD;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        cmd.op = ffha_pkg::OP_A_CHK;
        if (!st.fit) state_nxt = S_A_RD;
        else if (st.split) state_nxt = S_A_SPL;
        else state_nxt = S_A_TK;
      end
      S_A_SPL: begin
        cmd.op    = ffha_pkg::OP_A_SPL;
        state_nxt = S_A_TK;
      end
      S_A_TK: begin
        cmd.op    = ffha_pkg::OP_A_TAKE;
        state_nxt = (st.split_done && st.nxt_in) ? S_LK_RD : S_DONE;
      end
      S_LK_RD: begin
        cmd.op    = ffha_pkg::OP_LK_RD;
        state_nxt = S_LK_WR;
      end
      S_LK_WR: begin
        cmd.op    = ffha_pkg::OP_LK_WR;
        state_nxt = S_DONE;
      end
      S_F_CHK: begin
        if (st.faddr_bad) begin
          cmd.op    = ffha_pkg::OP_FAIL_BAD;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffha_pkg::OP_F_RD;
          state_nxt = S_F_HDR;
        end
      end
      S_F_HDR: begin
        if (st.hdr_bad) begin
          cmd.op    = ffha_pkg::OP_FAIL_BAD;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffha_pkg::OP_F_MARK;
          state_nxt = st.cur_zero ? S_F_NRD : S_F_PRD;
        end
      end
      S_F_PRD: begin
        cmd.op    = ffha_pkg::OP_F_PRD;
        state_nxt = S_F_PCK;
      end
      S_F_PCK: begin
        if (st.nb_free) begin
          cmd.op    = ffha_pkg::OP_F_PMRG;
          state_nxt = S_F_INV;
        end else begin
          state_nxt = S_F_NRD;
        end
      end
      S_F_INV: begin
        cmd.op    = ffha_pkg::OP_F_INV;
        state_nxt = S_F_NRD;
      end
      S_F_NRD: begin
        if (st.nxt_in) begin
          cmd.op    = ffha_pkg::OP_F_NRD;
          state_nxt = S_F_NCK;
        end else begin
          state_nxt = S_F_LNK;
        end
      end
      S_F_NCK: begin
        if (st.nb_free) begin
          cmd.op    = ffha_pkg::OP_F_NMRG;
          state_nxt = S_F_INN;
        end else begin
          state_nxt = S_F_LNK;
        end
      end
      S_F_INN: begin
        cmd.op    = ffha_pkg::OP_F_INV;
        state_nxt = S_F_LNK;
      end
      S_F_LNK: begin
        cmd.op    = ffha_pkg::OP_F_LNK;
        state_nxt = st.lnk_in ? S_LK_RD : S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = ffha_pkg::OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

>>> src/ffha_dp.sv
module ffha_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffha_pkg::ctl_cmd_t            cmd,
  output ffha_pkg::dp_status_t          st,
  input  logic [ffha_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [ffha_pkg::FADDR_W-1:0]  in_free_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [ffha_pkg::BADDR_W-1:0]  out_block_addr,
  output logic [ffha_pkg::REM_W-1:0]    out_remaining
);

  localparam int AW = ffha_pkg::AW;
  localparam int OW = ffha_pkg::OW;
  localparam int CW = ffha_pkg::CW;
  localparam logic [OW-1:0] HDR_O  = OW'(ffha_pkg::HEADER_BYTES);
  localparam logic [OW-1:0] HEAP_O = OW'(ffha_pkg::HEAP_BYTES);

  // Request and walk registers
  logic [ffha_pkg::SIZE_W-1:0]  req_r, req_nxt;
  logic [ffha_pkg::FADDR_W-1:0] faddr_r, faddr_nxt;
  logic [OW-1:0]                off_r, off_nxt;
  logic [OW-1:0]                nxt_r, nxt_nxt;
  logic [AW-1:0]                own_r, own_nxt;
  logic [AW-1:0]                dead_r, dead_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic                         split_r, split_nxt;
  ffha_pkg::hdr_t               hdr_r, hdr_nxt;
  logic [OW-1:0]                fb_r, fb_nxt;
  ffha_pkg::status_t            res_st_r, res_st_nxt;
  logic [OW-1:0]                res_addr_r, res_addr_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [ffha_pkg::BADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ffha_pkg::REM_W-1:0]   out_rem_r, out_rem_nxt;

  // Header store port
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  ffha_pkg::hdr_t               ram_wdata;
  logic [ffha_pkg::HDR_W-1:0]   ram_rdata;
  ffha_pkg::hdr_t               rd;

  // Arithmetic helpers
  logic [OW-1:0]  off_adv;
  logic [OW-1:0]  rest;
  logic [OW-1:0]  taken;
  logic [OW:0]    fb_sum;
  logic [OW-1:0]  lnk_end;
  logic [OW-1:0]  faddr_cur;
  logic [AW-1:0]  merged_sz;
  logic [AW-1:0]  nmerged_sz;

  ffha_ram #(.W(ffha_pkg::HDR_W), .D(ffha_pkg::HEAP_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd         = ffha_pkg::hdr_t'(ram_rdata);
  assign off_adv    = off_r + HDR_O + OW'(rd.size);
  assign rest       = off_r + HDR_O + OW'(req_r);
  assign taken      = OW'(hdr_r.size) + HDR_O;
  assign fb_sum     = (OW+1)'(fb_r) + (OW+1)'(rd.size) + (OW+1)'(HDR_O);
  assign lnk_end    = off_r + HDR_O + OW'(hdr_r.size);
  assign faddr_cur  = OW'(faddr_r - ffha_pkg::FADDR_W'(ffha_pkg::HEADER_BYTES));
  assign merged_sz  = rd.size + AW'(ffha_pkg::HEADER_BYTES) + hdr_r.size;
  assign nmerged_sz = hdr_r.size + AW'(ffha_pkg::HEADER_BYTES) + rd.size;

  // Status toward the controller
  always_comb begin
    st.clr_last   = (clr_r == AW'(ffha_pkg::HEAP_BYTES - 1));
    st.off_end    = (off_r >= HEAP_O);
    st.fit        = rd.free && (CW'(rd.size) >= CW'(req_r));
    st.split      = CW'(rd.size) >= (CW'(req_r) + CW'(ffha_pkg::HEADER_BYTES));
    st.faddr_bad  = (CW'(faddr_r) >= CW'(ffha_pkg::HEAP_BYTES)) ||
                    (CW'(faddr_r) < CW'(ffha_pkg::HEADER_BYTES));
    st.hdr_bad    = !rd.valid || rd.free;
    st.cur_zero   = (off_r == '0);
    st.nb_free    = rd.valid && rd.free;
    st.nxt_in     = (nxt_r < HEAP_O);
    st.lnk_in     = (lnk_end < HEAP_O);
    st.split_done = split_r;
    st.out_free   = !out_valid_r || out_ready;
  end

  // Micro-operation execution
  always_comb begin
    req_nxt        = req_r;
    faddr_nxt      = faddr_r;
    off_nxt        = off_r;
    nxt_nxt        = nxt_r;
    own_nxt        = own_r;
    dead_nxt       = dead_r;
    clr_nxt        = clr_r;
    split_nxt      = split_r;
    hdr_nxt        = hdr_r;
    fb_nxt         = fb_r;
    res_st_nxt     = res_st_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_rem_nxt    = out_rem_r;
    ram_we         = 1'b0;
    ram_addr       = off_r[AW-1:0];
    ram_wdata      = hdr_r;
    case (cmd.op)
      ffha_pkg::OP_CLR: begin
        // Sweep the store; offset zero holds the single free block
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        if (clr_r == '0) begin
          ram_wdata.valid = 1'b1;
          ram_wdata.free  = 1'b1;
          ram_wdata.size  = AW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
        end
        clr_nxt = clr_r + AW'(1);
      end
      ffha_pkg::OP_LATCH: begin
        req_nxt      = in_alloc_size;
        faddr_nxt    = in_free_addr;
        off_nxt      = '0;
        split_nxt    = 1'b0;
        res_st_nxt   = ffha_pkg::ST_OK;
        res_addr_nxt = '0;
      end
      ffha_pkg::OP_A_RD: begin
        ram_addr = off_r[AW-1:0];
      end
      ffha_pkg::OP_A_CHK: begin
        hdr_nxt = rd;
        if (!st.fit) off_nxt = off_adv;
      end
      ffha_pkg::OP_A_SPL: begin
        // Leftover becomes a new free block right after the request
        ram_we          = 1'b1;
        ram_addr        = rest[AW-1:0];
        ram_wdata.valid = 1'b1;
        ram_wdata.free  = 1'b1;
        ram_wdata.size  = AW'(CW'(hdr_r.size) - CW'(req_r) - CW'(ffha_pkg::HEADER_BYTES));
        ram_wdata.prev  = off_r[AW-1:0];
        nxt_nxt         = lnk_end;
        own_nxt         = rest[AW-1:0];
        split_nxt       = 1'b1;
        hdr_nxt.size    = AW'(req_r);
      end
      ffha_pkg::OP_A_TAKE: begin
        ram_we         = 1'b1;
        ram_addr       = off_r[AW-1:0];
        ram_wdata      = hdr_r;
        ram_wdata.free = 1'b0;
        fb_nxt         = (fb_r > taken) ? fb_r - taken : '0;
        res_addr_nxt   = off_r + HDR_O;
      end
      ffha_pkg::OP_FAIL_NS: begin
        res_st_nxt   = ffha_pkg::ST_NOSPACE;
        res_addr_nxt = '0;
      end
      ffha_pkg::OP_FAIL_BAD: begin
        res_st_nxt   = ffha_pkg::ST_BADADDR;
        res_addr_nxt = '0;
      end
      ffha_pkg::OP_LK_RD: begin
        ram_addr = nxt_r[AW-1:0];
      end
      ffha_pkg::OP_LK_WR: begin
        // Point the following block back at the block that changed
        ram_we         = 1'b1;
        ram_addr       = nxt_r[AW-1:0];
        ram_wdata      = rd;
        ram_wdata.prev = own_r;
      end
      ffha_pkg::OP_F_RD: begin
        off_nxt  = faddr_cur;
        ram_addr = faddr_cur[AW-1:0];
      end
      ffha_pkg::OP_F_MARK: begin
        hdr_nxt        = rd;
        hdr_nxt.free   = 1'b1;
        ram_we         = 1'b1;
        ram_addr       = off_r[AW-1:0];
        ram_wdata      = rd;
        ram_wdata.free = 1'b1;
        fb_nxt         = (fb_sum > (OW+1)'(HEAP_O)) ? HEAP_O : fb_sum[OW-1:0];
        nxt_nxt        = off_adv;
      end
      ffha_pkg::OP_F_PRD: begin
        ram_addr = hdr_r.prev;
      end
      ffha_pkg::OP_F_PMRG: begin
        // Fold the freed block into its free predecessor
        ram_we         = 1'b1;
        ram_addr       = hdr_r.prev;
        ram_wdata      = rd;
        ram_wdata.size = merged_sz;
        hdr_nxt        = rd;
        hdr_nxt.size   = merged_sz;
        dead_nxt       = off_r[AW-1:0];
        off_nxt        = OW'(hdr_r.prev);
      end
      ffha_pkg::OP_F_INV: begin
        ram_we    = 1'b1;
        ram_addr  = dead_r;
        ram_wdata = '0;
      end
      ffha_pkg::OP_F_NRD: begin
        ram_addr = nxt_r[AW-1:0];
      end
      ffha_pkg::OP_F_NMRG: begin
        // Absorb the free successor into the current block
        ram_we         = 1'b1;
        ram_addr       = off_r[AW-1:0];
        ram_wdata      = hdr_r;
        ram_wdata.size = nmerged_sz;
        hdr_nxt.size   = nmerged_sz;
        dead_nxt       = nxt_r[AW-1:0];
      end
      ffha_pkg::OP_F_LNK: begin
        nxt_nxt = lnk_end;
        own_nxt = off_r[AW-1:0];
      end
      ffha_pkg::OP_DONE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_st_r;
        out_addr_nxt   = res_addr_r[ffha_pkg::BADDR_W-1:0];
        out_rem_nxt    = ffha_pkg::REM_W'(fb_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      fb_r        <= HEAP_O;
      out_valid_r <= 1'b0;
      split_r     <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
      split_r     <= split_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    faddr_r      <= faddr_nxt;
    off_r        <= off_nxt;
    nxt_r        <= nxt_nxt;
    own_r        <= own_nxt;
    dead_r       <= dead_nxt;
    hdr_r        <= hdr_nxt;
    res_st_r     <= res_st_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_addr = out_addr_r;
  assign out_remaining  = out_rem_r;

endmodule

>>> src/ffha_chk.sv
module ffha_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [ffha_pkg::BADDR_W-1:0]  out_block_addr,
  input logic [ffha_pkg::REM_W-1:0]    out_remaining
);

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_block_addr) && $stable(out_remaining))
    else $error("result changed while stalled");

  // One request at a time: no accept right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ffha_pkg::ST_BADADDR)
    else $error("unknown status code");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |-> out_block_addr == '0)
    else $error("failed request with nonzero address");

  a_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_remaining <= ffha_pkg::REM_W'(ffha_pkg::HEAP_BYTES))
    else $error("free counter above heap size");

endmodule

bind first_fit_heap_allocator_core ffha_chk u_ffha_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_block_addr (out_chan.block_addr),
  .out_remaining  (out_chan.remaining)
);

>>> dv/tb_first_fit_heap_allocator_core.sv
module tb_first_fit_heap_allocator_core;

  localparam int ALLOC_SZ_MAX = 4096;
  localparam int IDLE_LIMIT   = 40000;
  localparam int NUM_RANDOM   = 880;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffha_in_if  in_chan ();
  ffha_out_if out_chan ();

  first_fit_heap_allocator_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One request as the sender offers it.
  typedef struct {
    logic                          kind;
    logic [ffha_pkg::SIZE_W-1:0]   size;
    logic [ffha_pkg::FADDR_W-1:0]  addr;
  } heap_req_t;

  // One result of the block.
  typedef struct {
    ffha_pkg::status_t             status;
    logic [ffha_pkg::BADDR_W-1:0]  block_addr;
    logic [ffha_pkg::REM_W-1:0]    remaining;
  } heap_rsp_t;

  // Directed row: the request and, where known at a glance, its result.
  typedef struct {
    heap_req_t req;
    bit        known;
    heap_rsp_t rsp;
  } dir_row_t;

  // Shadow of the heap: one header slot per byte offset.
  bit          blk_valid [ffha_pkg::HEAP_BYTES];
  bit          blk_free  [ffha_pkg::HEAP_BYTES];
  int unsigned blk_size  [ffha_pkg::HEAP_BYTES];
  int unsigned blk_prev  [ffha_pkg::HEAP_BYTES];
  int unsigned shadow_free_bytes;

  heap_rsp_t   pending_rsp[$];
  int unsigned live_addrs[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  bit          long_hold = 1'b0;

  function automatic void heap_reset();
    for (int i = 0; i < ffha_pkg::HEAP_BYTES; i++) begin
      blk_valid[i] = 1'b0;
      blk_free[i]  = 1'b0;
      blk_size[i]  = 0;
      blk_prev[i]  = 0;
    end
    blk_valid[0] = 1'b1;
    blk_free[0]  = 1'b1;
    blk_size[0]  = ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES;
    shadow_free_bytes = ffha_pkg::HEAP_BYTES;
  endfunction

  function automatic void relink_after(int unsigned off);
    int unsigned nxt;
    nxt = off + ffha_pkg::HEADER_BYTES + blk_size[off];
    if (nxt < ffha_pkg::HEAP_BYTES) blk_prev[nxt] = off;
  endfunction

  // First-fit allocate with split, or free with coalescing.
  function automatic heap_rsp_t heap_apply(heap_req_t req);
    heap_rsp_t   r;
    int unsigned off, rest, taken, cur, nxt, p, add, want;
    r.status = ffha_pkg::ST_BADADDR;
    r.block_addr = '0;
    if (req.kind == ffha_pkg::REQ_ALLOC) begin
      want = req.size;
      r.status = ffha_pkg::ST_NOSPACE;
      off = 0;
      while (off < ffha_pkg::HEAP_BYTES) begin
        if (blk_free[off] && blk_size[off] >= want) begin
          if (blk_size[off] >= want + ffha_pkg::HEADER_BYTES) begin
            rest = off + ffha_pkg::HEADER_BYTES + want;
            blk_valid[rest] = 1'b1;
            blk_free[rest]  = 1'b1;
            blk_size[rest]  = blk_size[off] - want - ffha_pkg::HEADER_BYTES;
            blk_prev[rest]  = off;
            blk_size[off]   = want;
            relink_after(rest);
          end
          blk_free[off] = 1'b0;
          taken = blk_size[off] + ffha_pkg::HEADER_BYTES;
          shadow_free_bytes = (shadow_free_bytes > taken) ?
                              shadow_free_bytes - taken : 0;
          r.status = ffha_pkg::ST_OK;
          r.block_addr = ffha_pkg::BADDR_W'(off + ffha_pkg::HEADER_BYTES);
          break;
        end
        off += ffha_pkg::HEADER_BYTES + blk_size[off];
      end
    end else if (req.addr < ffha_pkg::HEAP_BYTES && req.addr >= ffha_pkg::HEADER_BYTES) begin
      cur = req.addr - ffha_pkg::HEADER_BYTES;
      if (blk_valid[cur] && !blk_free[cur]) begin
        blk_free[cur] = 1'b1;
        add = shadow_free_bytes + blk_size[cur] + ffha_pkg::HEADER_BYTES;
        shadow_free_bytes = (add > ffha_pkg::HEAP_BYTES) ? ffha_pkg::HEAP_BYTES : add;
        nxt = cur + ffha_pkg::HEADER_BYTES + blk_size[cur];
        if (cur != 0) begin
          p = blk_prev[cur];
          if (p < ffha_pkg::HEAP_BYTES && blk_valid[p] && blk_free[p]) begin
            blk_size[p] += ffha_pkg::HEADER_BYTES + blk_size[cur];
            blk_valid[cur] = 1'b0;
            cur = p;
          end
        end
        if (nxt < ffha_pkg::HEAP_BYTES && blk_valid[nxt] && blk_free[nxt]) begin
          blk_size[cur] += ffha_pkg::HEADER_BYTES + blk_size[nxt];
          blk_valid[nxt] = 1'b0;
        end
        relink_after(cur);
        r.status = ffha_pkg::ST_OK;
      end
    end
    r.remaining = ffha_pkg::REM_W'(shadow_free_bytes);
    return r;
  endfunction

  // Pick a request: mostly frees of live blocks and small allocations.
  function automatic heap_req_t pick_request();
    heap_req_t q;
    int        sel, idx;
    q.kind = ffha_pkg::REQ_ALLOC;
    q.size = ffha_pkg::SIZE_W'($urandom_range(0, 200));
    q.addr = ffha_pkg::FADDR_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 40 && live_addrs.size() > 0) begin
      q.kind = ffha_pkg::REQ_FREE;
      idx = $urandom_range(0, live_addrs.size() - 1);
      q.addr = ffha_pkg::FADDR_W'(live_addrs[idx]);
      live_addrs.delete(idx);
    end else if (sel < 48) begin
      q.kind = ffha_pkg::REQ_FREE;
    end else if (sel < 52) begin
      q.size = ffha_pkg::SIZE_W'($urandom_range(0, 8191));
    end else if (sel < 56) begin
      q.size = ffha_pkg::SIZE_W'($urandom_range(1000, ALLOC_SZ_MAX));
    end
    return q;
  endfunction

  function automatic heap_req_t mk_req(logic kind, int unsigned size, int unsigned addr);
    heap_req_t q;
    q.kind = kind;
    q.size = ffha_pkg::SIZE_W'(size);
    q.addr = ffha_pkg::FADDR_W'(addr);
    return q;
  endfunction

  function automatic heap_rsp_t mk_rsp(ffha_pkg::status_t st, int unsigned baddr,
                                       int unsigned rem);
    heap_rsp_t r;
    r.status = st;
    r.block_addr = ffha_pkg::BADDR_W'(baddr);
    r.remaining = ffha_pkg::REM_W'(rem);
    return r;
  endfunction

  function automatic bit rsp_same(heap_rsp_t a, heap_rsp_t b);
    return (a.status == b.status) && (a.block_addr == b.block_addr) &&
           (a.remaining == b.remaining);
  endfunction

  dir_row_t dir_rows[$];

  // Directed table: extremes, both operations and each rejected free.
  initial begin
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 16), 1'b1,
                         mk_rsp(ffha_pkg::ST_BADADDR, 0, 4096)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 0, 0), 1'b1,
                         mk_rsp(ffha_pkg::ST_OK, 16, 4080)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 8191, 0), 1'b1,
                         mk_rsp(ffha_pkg::ST_NOSPACE, 0, 4080)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 4096, 0), 1'b1,
                         mk_rsp(ffha_pkg::ST_NOSPACE, 0, 4080)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 100, 8191), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 50, 0), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 8191), 1'b1,
                         mk_rsp(ffha_pkg::ST_BADADDR, 0, 3898)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 4096), 1'b1,
                         mk_rsp(ffha_pkg::ST_BADADDR, 0, 3898)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 0), 1'b1,
                         mk_rsp(ffha_pkg::ST_BADADDR, 0, 3898)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 15), 1'b1,
                         mk_rsp(ffha_pkg::ST_BADADDR, 0, 3898)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 33), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 48), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 48), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 164), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 16), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 4080, 0), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 0, 0), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 16), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 4070, 0), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 16), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_ALLOC, 4064, 0), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(ffha_pkg::REQ_FREE, 0, 16), 1'b0,
                         mk_rsp(ffha_pkg::ST_OK, 0, 0)});
  end

  // Offer one transaction after a random gap and predict its result.
  // Valid stays high after the accept; the next call or the caller drops it.
  task automatic send_req(heap_req_t q, bit known, heap_rsp_t want);
    int        gap;
    heap_rsp_t pred;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= q.kind;
    in_chan.alloc_size <= q.size;
    in_chan.free_addr  <= q.addr;
    @(posedge clk iff (in_chan.ready === 1'b1));
    pred = heap_apply(q);
    if (known && !rsp_same(pred, want)) begin
      $error("directed row: expected status %0d addr %0d rem %0d, got %0d %0d %0d",
             want.status, want.block_addr, want.remaining,
             pred.status, pred.block_addr, pred.remaining);
      err_count++;
    end
    if (q.kind == ffha_pkg::REQ_ALLOC && pred.status == ffha_pkg::ST_OK)
      live_addrs.push_back(pred.block_addr);
    pending_rsp.push_back(known ? want : pred);
  endtask

  // Stimulus.
  initial begin
    in_chan.valid      = 1'b0;
    in_chan.req_type   = ffha_pkg::REQ_ALLOC;
    in_chan.alloc_size = '0;
    in_chan.free_addr  = '0;
    heap_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) begin
        // Drain everything before going on.
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
      end
      if (n == 500) long_hold = 1'b1;
      send_req(pick_request(), 1'b0, mk_rsp(ffha_pkg::ST_OK, 0, 0));
    end
    in_chan.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls and one long hold-off.
  initial begin
    int wait_n;
    out_chan.ready = 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (wait_n != 0) begin
        out_chan.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk iff (out_chan.valid === 1'b1));
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    heap_rsp_t w;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: status %0d addr %0d rem %0d",
               out_chan.status, out_chan.block_addr, out_chan.remaining);
        err_count++;
      end else begin
        w = pending_rsp.pop_front();
        if (out_chan.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_chan.status);
          err_count++;
        end
        if (out_chan.block_addr !== w.block_addr) begin
          $error("block_addr: expected %0d, got %0d", w.block_addr, out_chan.block_addr);
          err_count++;
        end
        if (out_chan.remaining !== w.remaining) begin
          $error("remaining: expected %0d, got %0d", w.remaining, out_chan.remaining);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction; the reset sweep fits inside.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_ram.sv
src/ffha_ctrl.sv
src/ffha_dp.sv
src/first_fit_heap_allocator_core.sv
src/ffha_chk.sv
dv/tb_first_fit_heap_allocator_core.sv
